[hw/rtl/world_to_radar_transform_assert.svh]
// Assertion macros for the world-to-radar transform.
// Expect clk and rst_n in the scope of every use.
`ifndef WORLD_TO_RADAR_TRANSFORM_ASSERT_SVH
`define WORLD_TO_RADAR_TRANSFORM_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define WRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define WRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wrt_pkg.sv]
// Shared types and constants of the world-to-radar transform.
// No dependencies; used by the cells and the top level.
`default_nettype none
package wrt_pkg;

  localparam int ATAN_LEN = 24;
  localparam int FRAC = 16;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  localparam int CFG_AW = 3;
  localparam logic REG_MAX_RADIUS  = 1'b0;
  localparam logic REG_SCALE_SHIFT = 1'b1;
  localparam logic [8:0] MAX_RADIUS_RESET  = 9'd64;
  localparam logic [3:0] SCALE_SHIFT_RESET = 4'd5;

  localparam logic [31:0] HALF_TURN = 32'h80000000;
  localparam logic signed [31:0] QUARTER_POS = 32'sh40000000;
  localparam logic signed [31:0] QUARTER_NEG = 32'shC0000000;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic               flip;
    logic [15:0]        heading;
    logic signed [16:0] hd;
  } ctl_t;

endpackage
`default_nettype wire

[hw/rtl/wrt_if.sv]
// Item channels of the world-to-radar transform: object in, radar point out.
// No dependencies.
`default_nettype none
interface wrt_in_if #(parameter int COORD_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] viewer_x;
  logic signed [COORD_WIDTH-1:0] viewer_y;
  logic signed [COORD_WIDTH-1:0] viewer_z;
  logic signed [COORD_WIDTH-1:0] object_x;
  logic signed [COORD_WIDTH-1:0] object_y;
  logic signed [COORD_WIDTH-1:0] object_z;
  logic [15:0]                   heading;
  modport source (output valid, viewer_x, viewer_y, viewer_z, object_x, object_y,
                  object_z, heading, input ready);
  modport sink (input valid, viewer_x, viewer_y, viewer_z, object_x, object_y,
                object_z, heading, output ready);
endinterface

interface wrt_out_if;
  logic               valid;
  logic               ready;
  logic signed [9:0]  radar_x;
  logic signed [9:0]  radar_y;
  logic signed [16:0] height_diff;
  modport source (output valid, radar_x, radar_y, height_diff, input ready);
  modport sink (input valid, radar_x, radar_y, height_diff, output ready);
endinterface
`default_nettype wire

[hw/rtl/wrt_vec_cell.sv]
// One vectoring step of the bearing CORDIC: drives y to zero, sums the angle.
// Depends on wrt_pkg.
`default_nettype none
module wrt_vec_cell import wrt_pkg::*; #(
  parameter int STAGE = 0,
  parameter int VW    = 35
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire ctl_t                 ctl_i,
  input  wire logic signed [VW-1:0] x_i,
  input  wire logic signed [VW-1:0] y_i,
  input  wire logic [31:0]          ang_i,
  output ctl_t                      ctl_o,
  output logic signed [VW-1:0]      x_o,
  output logic signed [VW-1:0]      y_o,
  output logic [31:0]               ang_o
);

  ctl_t                 ctl_r;
  logic signed [VW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic [31:0]          ang_r, ang_nxt;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[VW-1]) begin
      x_nxt   = x_i + ys;
      y_nxt   = y_i - xs;
      ang_nxt = ang_i + ATAN_TAB[STAGE];
    end else begin
      x_nxt   = x_i - ys;
      y_nxt   = y_i + xs;
      ang_nxt = ang_i - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign ang_o = ang_r;

endmodule
`default_nettype wire

[hw/rtl/wrt_rot_cell.sv]
// One rotation step of the radar CORDIC: turns the radius, drives the angle to zero.
// Depends on wrt_pkg.
`default_nettype none
module wrt_rot_cell import wrt_pkg::*; #(
  parameter int STAGE = 0,
  parameter int RW    = 27
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire ctl_t                 ctl_i,
  input  wire logic signed [RW-1:0] x_i,
  input  wire logic signed [RW-1:0] y_i,
  input  wire logic [31:0]          ang_i,
  output ctl_t                      ctl_o,
  output logic signed [RW-1:0]      x_o,
  output logic signed [RW-1:0]      y_o,
  output logic [31:0]               ang_o
);

  ctl_t                 ctl_r;
  logic signed [RW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic [31:0]          ang_r, ang_nxt;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!ang_i[31]) begin
      x_nxt   = x_i - ys;
      y_nxt   = y_i + xs;
      ang_nxt = ang_i - ATAN_TAB[STAGE];
    end else begin
      x_nxt   = x_i + ys;
      y_nxt   = y_i - xs;
      ang_nxt = ang_i + ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      ang_r <= ang_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign ang_o = ang_r;

endmodule
`default_nettype wire

[hw/rtl/world_to_radar_transform.sv]
// Top level of the world-to-radar transform: offset, bearing, clamp, rotation.
// Depends on wrt_pkg, wrt_if, wrt_vec_cell, wrt_rot_cell and the assertion header.
//
// Takes one object item per clock while the result side does not stall and returns one
// radar point per item, in order. The pipeline is made of the offset stage, the two rows
// of CORDIC cells, one cell per iteration, two stages of gain multiply, the scale and
// clamp stage, and two stages of final gain and output. When the result side stalls,
// the whole row holds and in_ch.ready drops.
// Registers (APB, 32-bit data): byte 0 max_radius, byte 4 scale_shift; write them
// only while no item is in flight.
`default_nettype none
module world_to_radar_transform import wrt_pkg::*; #(
  parameter int COORD_WIDTH       = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  wrt_in_if.sink                 in_ch,
  wrt_out_if.source              out_ch,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int N  = CORDIC_ITERATIONS;
  localparam int DW = COORD_WIDTH + 1;
  localparam int VW = (COORD_WIDTH + 19 > 34) ? COORD_WIDTH + 19 : 34;
  localparam int HW = VW - 32;
  localparam int MW = HW + 33;
  localparam int RW = 27;
  localparam int PW = RW + 32;

  // Configuration
  logic [8:0] max_radius_r;
  logic [3:0] scale_shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_radius_r  <= MAX_RADIUS_RESET;
      scale_shift_r <= SCALE_SHIFT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_MAX_RADIUS:  max_radius_r  <= cfg_pwdata[8:0];
        REG_SCALE_SHIFT: scale_shift_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_MAX_RADIUS:  cfg_prdata = {23'd0, max_radius_r};
      REG_SCALE_SHIFT: cfg_prdata = {28'd0, scale_shift_r};
      default:         cfg_prdata = '0;
    endcase
  end
  assign cfg_pready = 1'b1;

  ctl_t out_ctl_r;
  logic en;
  assign en          = !out_ctl_r.valid || out_ch.ready;
  assign in_ch.ready = en;

  // Offset stage
  logic signed [DW-1:0] dx, dy, hd;
  logic signed [33:0]   hd_w;
  logic signed [VW-1:0] x0_nxt, y0_nxt;
  logic [31:0]          b0_nxt;
  ctl_t                 ctl0_nxt;

  always_comb begin
    dx     = DW'(in_ch.object_x) - DW'(in_ch.viewer_x);
    dy     = DW'(in_ch.object_y) - DW'(in_ch.viewer_y);
    hd     = DW'(in_ch.viewer_z) - DW'(in_ch.object_z);
    hd_w   = 34'(hd);
    x0_nxt = VW'(dx) <<< FRAC;
    y0_nxt = VW'(dy) <<< FRAC;
    b0_nxt = '0;
    if (dx[DW-1]) begin
      x0_nxt = -x0_nxt;
      y0_nxt = -y0_nxt;
      b0_nxt = HALF_TURN;
    end
    ctl0_nxt.valid   = in_ch.valid;
    ctl0_nxt.zero    = (dx == '0) && (dy == '0);
    ctl0_nxt.flip    = 1'b0;
    ctl0_nxt.heading = in_ch.heading;
    if (hd_w > 34'sd65535) begin
      ctl0_nxt.hd = 17'sd65535;
    end else if (hd_w < -34'sd65536) begin
      ctl0_nxt.hd = -17'sd65536;
    end else begin
      ctl0_nxt.hd = 17'(hd_w);
    end
  end

  ctl_t                 vctl [N+1];
  logic signed [VW-1:0] vx   [N+1];
  logic signed [VW-1:0] vy   [N+1];
  logic [31:0]          vb   [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vctl[0] <= '0;
    end else if (en) begin
      vctl[0] <= ctl0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0] <= x0_nxt;
      vy[0] <= y0_nxt;
      vb[0] <= b0_nxt;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_vec
    wrt_vec_cell #(.STAGE(g), .VW(VW)) u_cell (
      .clk, .rst_n, .en,
      .ctl_i(vctl[g]), .x_i(vx[g]), .y_i(vy[g]), .ang_i(vb[g]),
      .ctl_o(vctl[g+1]), .x_o(vx[g+1]), .y_o(vy[g+1]), .ang_o(vb[g+1])
    );
  end

  // Gain removal on the length
  ctl_t          m1_ctl_r, m2_ctl_r, s3_ctl_r;
  logic [63:0]   p_lo_r, p_lo_nxt;
  logic [HW+31:0] p_hi_r, p_hi_nxt;
  logic [VW-1:0] xa;
  logic [31:0]   m1_b_r, m2_b_r;
  logic [MW-1:0] sum_r, sum_nxt;

  always_comb begin
    xa       = vx[N][VW-1] ? '0 : vx[N];
    p_lo_nxt = 64'(xa[31:0]) * 64'(INV_GAIN);
    p_hi_nxt = (HW+32)'(xa[VW-1:32]) * (HW+32)'(INV_GAIN);
    sum_nxt  = MW'(p_hi_r) + MW'(p_lo_r[63:32]);
  end

  // Scale, clamp and rotation angle
  logic [MW-1:0]       shifted;
  logic [24:0]         lim, mag_nxt;
  logic signed [31:0]  t_raw, t_nxt;
  ctl_t                ctl3_nxt;
  logic signed [RW-1:0] rx [N+1];
  logic signed [RW-1:0] ry [N+1];
  logic [31:0]          rt [N+1];
  ctl_t                 rctl [N+1];

  always_comb begin
    shifted  = sum_r >> scale_shift_r;
    lim      = {max_radius_r, 16'd0};
    mag_nxt  = (shifted > MW'(lim)) ? lim : shifted[24:0];
    t_raw    = $signed({m2_ctl_r.heading, 16'd0} - m2_b_r);
    ctl3_nxt = m2_ctl_r;
    t_nxt    = t_raw;
    if (t_raw > QUARTER_POS || t_raw < QUARTER_NEG) begin
      t_nxt         = t_raw ^ HALF_TURN;
      ctl3_nxt.flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_ctl_r <= '0;
      m2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else if (en) begin
      m1_ctl_r <= vctl[N];
      m2_ctl_r <= m1_ctl_r;
      s3_ctl_r <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r <= p_lo_nxt;
      p_hi_r <= p_hi_nxt;
      m1_b_r <= vb[N];
      sum_r  <= sum_nxt;
      m2_b_r <= m1_b_r;
      rx[0]  <= RW'(mag_nxt);
      ry[0]  <= '0;
      rt[0]  <= t_nxt;
    end
  end

  assign rctl[0] = s3_ctl_r;

  for (genvar g = 0; g < N; g++) begin : g_rot
    wrt_rot_cell #(.STAGE(g), .RW(RW)) u_cell (
      .clk, .rst_n, .en,
      .ctl_i(rctl[g]), .x_i(rx[g]), .y_i(ry[g]), .ang_i(rt[g]),
      .ctl_o(rctl[g+1]), .x_o(rx[g+1]), .y_o(ry[g+1]), .ang_o(rt[g+1])
    );
  end

  // Final gain removal, sign, truncation and saturation
  ctl_t          g1_ctl_r;
  logic [PW-1:0] px_r, py_r, px_nxt, py_nxt;
  logic          sx_r, sy_r;
  logic [RW-1:0] ax, ay;
  logic [10:0]   qx, qy;
  logic          neg_rx, neg_ry;
  logic signed [9:0] rad_x_nxt, rad_y_nxt;
  logic signed [9:0] rad_x_r, rad_y_r;
  logic signed [16:0] hd_r;

  always_comb begin
    ax     = rx[N][RW-1] ? RW'(-rx[N]) : RW'(rx[N]);
    ay     = ry[N][RW-1] ? RW'(-ry[N]) : RW'(ry[N]);
    px_nxt = PW'(ax) * PW'(INV_GAIN);
    py_nxt = PW'(ay) * PW'(INV_GAIN);
    qx     = px_r[PW-1:32+FRAC];
    qy     = py_r[PW-1:32+FRAC];
    neg_rx = sy_r ^ g1_ctl_r.flip;
    neg_ry = !(sx_r ^ g1_ctl_r.flip);
    if (neg_rx) begin
      rad_x_nxt = (qy > 11'd512) ? -10'sd512 : 10'(-qy);
    end else begin
      rad_x_nxt = (qy > 11'd511) ? 10'sd511 : 10'(qy);
    end
    if (neg_ry) begin
      rad_y_nxt = (qx > 11'd512) ? -10'sd512 : 10'(-qx);
    end else begin
      rad_y_nxt = (qx > 11'd511) ? 10'sd511 : 10'(qx);
    end
    if (g1_ctl_r.zero) begin
      rad_x_nxt = '0;
      rad_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_ctl_r  <= '0;
      out_ctl_r <= '0;
    end else if (en) begin
      g1_ctl_r  <= rctl[N];
      out_ctl_r <= g1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      sx_r    <= rx[N][RW-1];
      sy_r    <= ry[N][RW-1];
      rad_x_r <= rad_x_nxt;
      rad_y_r <= rad_y_nxt;
      hd_r    <= g1_ctl_r.hd;
    end
  end

  assign out_ch.valid       = out_ctl_r.valid;
  assign out_ch.radar_x     = rad_x_r;
  assign out_ch.radar_y     = rad_y_r;
  assign out_ch.height_diff = hd_r;

`include "world_to_radar_transform_assert.svh"

  `WRT_ASSERT_NXT(a_accept_enters, in_ch.valid && in_ch.ready, vctl[0].valid,
                  "accepted item did not enter the offset stage")
  `WRT_ASSERT_IMP(a_zero_offset, out_ctl_r.valid && out_ctl_r.zero,
                  rad_x_r == '0 && rad_y_r == '0, "zero offset gave a non-zero point")
  `WRT_ASSERT_NXT(a_clamp, en && m2_ctl_r.valid, rx[0] <= RW'({max_radius_r, 16'd0}),
                  "radius above max_radius")
  `WRT_ASSERT_IMP(a_angle_range, s3_ctl_r.valid,
                  $signed(rt[0]) <= QUARTER_POS && $signed(rt[0]) >= QUARTER_NEG,
                  "rotation angle outside a quarter turn")

endmodule
`default_nettype wire

[verif/world_to_radar_transform_tb.sv]
// Self-checking testbench for world_to_radar_transform: drives object items, predicts
// each radar point with a bit-exact fixed-point CORDIC model and checks every result.
// Depends on wrt_pkg, wrt_in_if, wrt_out_if and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module world_to_radar_transform_tb;
  import wrt_pkg::*;

  typedef struct packed {
    logic signed [9:0]  radar_x;
    logic signed [9:0]  radar_y;
    logic signed [16:0] height_diff;
  } radar_pt_t;

  localparam int LATENCY = 38;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  wrt_in_if #(.COORD_WIDTH(16)) in_ch ();
  wrt_out_if out_ch ();

  world_to_radar_transform DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  logic [8:0] radius_lim;
  logic [3:0] shift_amt;
  radar_pt_t  pending_pts[$];
  int         mismatches;
  int         points_seen;
  int         items_sent;
  longint     cycles;
  bit         in_idle_on, out_idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("world_to_radar_transform_tb: done, errors");
      $finish;
    end
  end

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint drop_gain(longint v);
    logic [63:0] m;
    logic [127:0] p;
    m = (v < 0) ? -v : v;
    p = m * 64'(INV_GAIN);
    return (v < 0) ? -longint'(p[95:32]) : longint'(p[95:32]);
  endfunction

  function automatic logic signed [9:0] pix_sat(longint v);
    longint q;
    q = (v < 0) ? -((-v) >>> FRAC) : (v >>> FRAC);
    if (q > 511) q = 511;
    if (q < -512) q = -512;
    return q[9:0];
  endfunction

  function automatic radar_pt_t project_point(logic signed [15:0] vx, logic signed [15:0] vy,
      logic signed [15:0] vz, logic signed [15:0] ox, logic signed [15:0] oy,
      logic signed [15:0] oz, logic [15:0] hdg);
    radar_pt_t r;
    longint dx, dy, hd, x, y, nx, mag, lim, t;
    logic [31:0] brg, ang;
    bit flip;
    dx = longint'(ox) - longint'(vx);
    dy = longint'(oy) - longint'(vy);
    hd = longint'(vz) - longint'(oz);
    r.height_diff = hd[16:0];
    r.radar_x = '0;
    r.radar_y = '0;
    if (dx == 0 && dy == 0) return r;
    x = dx * 65536;
    y = dy * 65536;
    brg = '0;
    flip = 0;
    if (x < 0) begin
      x = -x; y = -y; brg = HALF_TURN;
    end
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + sra(y, i); y = y - sra(x, i); brg = brg + ATAN_TAB[i];
      end else begin
        nx = x - sra(y, i); y = y + sra(x, i); brg = brg - ATAN_TAB[i];
      end
      x = nx;
    end
    mag = drop_gain(x);
    if (mag < 0) mag = 0;
    mag = mag >>> shift_amt;
    lim = longint'(radius_lim) * 65536;
    if (mag > lim) mag = lim;
    ang = {hdg, 16'h0} - brg;
    t = longint'(signed'(ang));
    if (t > 64'sh40000000) begin
      t -= 64'sh80000000; flip = 1;
    end else if (t < -64'sh40000000) begin
      t += 64'sh80000000; flip = 1;
    end
    x = mag;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (t >= 0) begin
        nx = x - sra(y, i); y = y + sra(x, i); t -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + sra(y, i); y = y - sra(x, i); t += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    x = drop_gain(x);
    y = drop_gain(y);
    if (flip) begin
      x = -x; y = -y;
    end
    r.radar_x = pix_sat(y);
    r.radar_y = pix_sat(-x);
    return r;
  endfunction

  always @(posedge clk) begin
    radar_pt_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.radar_x, out_ch.radar_y, out_ch.height_diff};
      points_seen++;
      if (pending_pts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point %p", got);
      end else begin
        want = pending_pts.pop_front();
        if (got.radar_x !== want.radar_x || got.radar_y !== want.radar_y ||
            got.height_diff !== want.height_diff) begin
          mismatches++;
          if (mismatches <= 10) $display("point mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= out_idle_on ? ($urandom_range(99) >= 25) : 1'b1;
  end

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    if (addr == CFG_AW'(4 * REG_MAX_RADIUS)) radius_lim = data[8:0];
    else if (addr == CFG_AW'(4 * REG_SCALE_SHIFT)) shift_amt = data[3:0];
  endtask

  task automatic set_scale(logic [8:0] rad, logic [3:0] sh);
    write_reg(CFG_AW'(4 * REG_MAX_RADIUS), 32'(rad));
    write_reg(CFG_AW'(4 * REG_SCALE_SHIFT), 32'(sh));
  endtask

  // one item; valid held across back-to-back sends
  task automatic send_object(logic signed [15:0] vx, logic signed [15:0] vy,
      logic signed [15:0] vz, logic signed [15:0] ox, logic signed [15:0] oy,
      logic signed [15:0] oz, logic [15:0] hdg);
    while (in_idle_on && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.viewer_x <= vx; in_ch.viewer_y <= vy; in_ch.viewer_z <= vz;
    in_ch.object_x <= ox; in_ch.object_y <= oy; in_ch.object_z <= oz;
    in_ch.heading <= hdg;
    do @(posedge clk); while (!in_ch.ready);
    pending_pts.push_back(project_point(vx, vy, vz, ox, oy, oz, hdg));
    items_sent++;
  endtask

  task automatic drain_points();
    in_ch.valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_random_object(int span);
    logic signed [15:0] vx, vy, ox, oy;
    vx = 16'($urandom); vy = 16'($urandom);
    ox = vx + 16'($signed($urandom_range(2 * span)) - span);
    oy = vy + 16'($signed($urandom_range(2 * span)) - span);
    if ($urandom_range(9) == 0) begin
      ox = 16'($urandom); oy = 16'($urandom);
    end
    send_object(vx, vy, 16'($urandom), ox, oy, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    send_object(0, 0, 0, 0, 0, 0, 0);
    send_object(100, -200, 32767, 100, -200, -32768, 16'h1234);
    send_object(-32768, -32768, -32768, 32767, 32767, 32767, 16'hFFFF);
    send_object(32767, 32767, 32767, -32768, -32768, -32768, 16'h0000);
    send_object(0, 0, 5, 1000, 0, 7, 16'h4000);
    send_object(0, 0, 5, -1000, 0, 7, 16'h8000);
    send_object(0, 0, 5, 0, 1000, 7, 16'hC000);
    send_object(0, 0, 5, 0, -1000, 7, 16'h2000);
    send_object(0, 0, 0, 1, 0, 0, 16'h0000);
    send_object(0, 0, 0, -1, -1, 0, 16'h6000);
    send_object(0, 0, 0, 3, -700, 0, 16'hA000);
    send_object(0, 0, 0, 20000, 20000, 0, 16'hE000);
    drain_points();
  endtask

  task automatic test_register_extremes();
    set_scale(9'd511, 4'd0);
    test_directed();
    set_scale(9'd0, 4'd15);
    test_directed();
    set_scale(9'd511, 4'd15);
    test_directed();
  endtask

  task automatic test_random_objects(int n);
    for (int k = 0; k < n; k++) begin
      set_scale(9'($urandom_range(511)), 4'($urandom_range(15)));
      for (int j = 0; j < 100; j++) send_random_object($urandom_range(1) ? 3000 : 30);
      drain_points();
    end
  endtask

  task automatic test_back_to_back();
    in_idle_on = 0; out_idle_on = 0;
    set_scale(9'd200, 4'd3);
    for (int j = 0; j < 150; j++) send_random_object(1500);
    drain_points();
    in_idle_on = 1; out_idle_on = 1;
  endtask

  initial begin
    rst_n = 1'b0; cycles = 0; mismatches = 0; points_seen = 0; items_sent = 0;
    in_idle_on = 1; out_idle_on = 1;
    radius_lim = MAX_RADIUS_RESET; shift_amt = SCALE_SHIFT_RESET;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    in_ch.valid = 0; in_ch.viewer_x = 0; in_ch.viewer_y = 0; in_ch.viewer_z = 0;
    in_ch.object_x = 0; in_ch.object_y = 0; in_ch.object_z = 0; in_ch.heading = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_back_to_back();
    test_random_objects(6);
    $display("covered %0d items and %0d points over register extremes and random scales",
             items_sent, points_seen);
    if (mismatches == 0) $display("world_to_radar_transform_tb: done, clean");
    else $display("world_to_radar_transform_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hw/rtl
hw/rtl/wrt_pkg.sv
hw/rtl/wrt_if.sv
hw/rtl/wrt_vec_cell.sv
hw/rtl/wrt_rot_cell.sv
hw/rtl/world_to_radar_transform.sv
verif/world_to_radar_transform_tb.sv
